@@ design/mi4_pkg.sv @@
// Package for the 4x4 matrix inverse unit: widths, fixed-point helpers,
// scratch memory map and the micro-op sequence of one inverse run.
// No dependencies.
package mi4_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 4;
  localparam int ADDR_W     = 6;
  localparam int MEM_DEPTH  = 64;
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  localparam int RND_W      = 2 * ELEM_WIDTH + 1 - FRAC_BITS;
  localparam int NUM_W      =
    ((2 * FRAC_BITS > ELEM_WIDTH - 1) ? 2 * FRAC_BITS : ELEM_WIDTH - 1) + 1;
  localparam int MAG_W      = (RND_W > NUM_W) ? RND_W : NUM_W;
  localparam int DIV_CW     = $clog2(NUM_W);

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  localparam elem_t ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
  localparam idx_t  LAST_IDX = '1;

  // scratch map: matrix 0..15, minors 16..33, cofactors 34..49, reciprocal 50
  localparam addr_t MINOR_BASE = 6'd16;
  localparam addr_t COF_BASE   = 6'd34;
  localparam addr_t INV_ADDR   = 6'd50;

  typedef enum logic [1:0] {OP_FIRST, OP_SUB, OP_ADD} op_t;
  typedef enum logic [2:0] {END_NONE, END_STORE, END_MINOR, END_DET, END_OUT} fin_t;
  typedef enum logic [3:0] {
    SEC_MINOR = 4'b0001,
    SEC_COFAC = 4'b0010,
    SEC_DET   = 4'b0100,
    SEC_RES   = 4'b1000
  } sec_t;

  typedef struct packed {
    op_t   op;
    addr_t a_addr;
    addr_t b_addr;
    logic  neg_a;
    fin_t  fin;
    addr_t dest;
  } uop_t;

  // {clip, value}: sign a magnitude and clip it to the element range
  function automatic logic [ELEM_WIDTH:0] from_mag(input logic neg,
                                                   input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] lim;
    lim = {{(MAG_W-ELEM_WIDTH){1'b0}}, ELEM_MAX} + MAG_W'(neg);
    if (mag > lim) return {1'b1, (neg ? ELEM_MIN : ELEM_MAX)};
    if (neg) return {1'b0, -mag[ELEM_WIDTH-1:0]};
    return {1'b0, mag[ELEM_WIDTH-1:0]};
  endfunction

  // {clip, value}: saturating a + b or a - b
  function automatic logic [ELEM_WIDTH:0] sat_addsub(input elem_t a, input elem_t b,
                                                     input logic sub);
    logic [ELEM_WIDTH:0] s;
    if (sub) s = {a[ELEM_WIDTH-1], a} - {b[ELEM_WIDTH-1], b};
    else     s = {a[ELEM_WIDTH-1], a} + {b[ELEM_WIDTH-1], b};
    if (s[ELEM_WIDTH] != s[ELEM_WIDTH-1])
      return {1'b1, (s[ELEM_WIDTH] ? ELEM_MIN : ELEM_MAX)};
    return {1'b0, s[ELEM_WIDTH-1:0]};
  endfunction

  // 2x2 minor m: {col a, col b, row c, row d}
  function automatic logic [7:0] minor_map(input logic [4:0] m);
    case (m)
      5'd0:    return {2'd2, 2'd3, 2'd2, 2'd3};
      5'd1:    return {2'd1, 2'd3, 2'd2, 2'd3};
      5'd2:    return {2'd1, 2'd2, 2'd2, 2'd3};
      5'd3:    return {2'd0, 2'd3, 2'd2, 2'd3};
      5'd4:    return {2'd0, 2'd2, 2'd2, 2'd3};
      5'd5:    return {2'd0, 2'd1, 2'd2, 2'd3};
      5'd6:    return {2'd2, 2'd3, 2'd1, 2'd3};
      5'd7:    return {2'd1, 2'd3, 2'd1, 2'd3};
      5'd8:    return {2'd1, 2'd2, 2'd1, 2'd3};
      5'd9:    return {2'd2, 2'd3, 2'd1, 2'd2};
      5'd10:   return {2'd1, 2'd3, 2'd1, 2'd2};
      5'd11:   return {2'd1, 2'd2, 2'd1, 2'd2};
      5'd12:   return {2'd0, 2'd3, 2'd1, 2'd3};
      5'd13:   return {2'd0, 2'd2, 2'd1, 2'd3};
      5'd14:   return {2'd0, 2'd3, 2'd1, 2'd2};
      5'd15:   return {2'd0, 2'd2, 2'd1, 2'd2};
      5'd16:   return {2'd0, 2'd1, 2'd1, 2'd3};
      5'd17:   return {2'd0, 2'd1, 2'd1, 2'd2};
      default: return '0;
    endcase
  endfunction

  // matrix addresses {x, y, z} of cofactor k: the other three columns
  function automatic logic [11:0] cof_elems(input logic [3:0] k);
    logic [1:0] r;
    r = (k < 4'd4) ? 2'd1 : 2'd0;
    case (k[1:0])
      2'd0:    return {2'd1, r, 2'd2, r, 2'd3, r};
      2'd1:    return {2'd0, r, 2'd2, r, 2'd3, r};
      2'd2:    return {2'd0, r, 2'd1, r, 2'd3, r};
      default: return {2'd0, r, 2'd1, r, 2'd2, r};
    endcase
  endfunction

  // minor numbers {u, v, w} of cofactor k
  function automatic logic [14:0] cof_minors(input logic [3:0] k);
    case (k)
      4'd0, 4'd4: return {5'd0, 5'd1, 5'd2};
      4'd1, 4'd5: return {5'd0, 5'd3, 5'd4};
      4'd2, 4'd6: return {5'd1, 5'd3, 5'd5};
      4'd3, 4'd7: return {5'd2, 5'd4, 5'd5};
      4'd8:       return {5'd6, 5'd7, 5'd8};
      4'd9:       return {5'd6, 5'd12, 5'd13};
      4'd10:      return {5'd7, 5'd12, 5'd16};
      4'd11:      return {5'd8, 5'd13, 5'd16};
      4'd12:      return {5'd9, 5'd10, 5'd11};
      4'd13:      return {5'd9, 5'd14, 5'd15};
      4'd14:      return {5'd10, 5'd14, 5'd17};
      default:    return {5'd11, 5'd15, 5'd17};
    endcase
  endfunction

  function automatic uop_t get_uop(input sec_t sec, input logic [4:0] k,
                                   input logic [1:0] j);
    uop_t u;
    logic [7:0]  mc;
    logic [11:0] xyz;
    logic [14:0] uvw;
    u.op = OP_FIRST;
    u.a_addr = '0;
    u.b_addr = '0;
    u.neg_a = 1'b0;
    u.fin = END_NONE;
    u.dest = '0;
    mc  = minor_map(k);
    xyz = cof_elems(k[3:0]);
    uvw = cof_minors(k[3:0]);
    case (sec)
      SEC_MINOR: begin
        if (!j[0]) begin
          u.a_addr = ADDR_W'({mc[7:6], mc[3:2]});
          u.b_addr = ADDR_W'({mc[5:4], mc[1:0]});
        end else begin
          u.op = OP_SUB;
          u.a_addr = ADDR_W'({mc[5:4], mc[3:2]});
          u.b_addr = ADDR_W'({mc[7:6], mc[1:0]});
          u.fin = END_MINOR;
          u.dest = MINOR_BASE + ADDR_W'(k);
        end
      end
      SEC_COFAC: begin
        case (j)
          2'd0: begin
            u.a_addr = ADDR_W'(xyz[11:8]);
            u.b_addr = MINOR_BASE + ADDR_W'(uvw[14:10]);
          end
          2'd1: begin
            u.op = OP_SUB;
            u.a_addr = ADDR_W'(xyz[7:4]);
            u.b_addr = MINOR_BASE + ADDR_W'(uvw[9:5]);
          end
          default: begin
            u.op = OP_ADD;
            u.a_addr = ADDR_W'(xyz[3:0]);
            u.b_addr = MINOR_BASE + ADDR_W'(uvw[4:0]);
            u.fin = END_STORE;
            u.dest = COF_BASE + ADDR_W'(k);
          end
        endcase
      end
      SEC_DET: begin
        // row 0 expansion: m00*p0 - m01*p1 + m02*p2 - m03*p3
        u.a_addr = ADDR_W'({j, 2'b00});
        u.b_addr = COF_BASE + ADDR_W'(j);
        case (j)
          2'd0:    u.op = OP_FIRST;
          2'd2:    u.op = OP_ADD;
          default: u.op = OP_SUB;
        endcase
        if (j == 2'd3) u.fin = END_DET;
      end
      SEC_RES: begin
        u.a_addr = COF_BASE + ADDR_W'(k);
        u.b_addr = INV_ADDR;
        u.neg_a = k[2] ^ k[0];
        u.fin = END_OUT;
      end
      default: u.fin = END_NONE;
    endcase
    return u;
  endfunction

endpackage

@@ design/mi4_in_if.sv @@
// Input channel of the matrix inverse unit: one matrix element per item.
// Depends on mi4_pkg.
interface mi4_in_if import mi4_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t element_value;
  idx_t  element_index;

  modport source(output valid, element_value, element_index, input ready);
  modport sink(input valid, element_value, element_index, output ready);
endinterface

@@ design/mi4_out_if.sv @@
// Output channel of the matrix inverse unit: one inverse element per item.
// Depends on mi4_pkg.
interface mi4_out_if import mi4_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t result_value;
  idx_t  result_index;
  logic  last_element;
  logic  singular;
  logic  saturated;

  modport source(output valid, result_value, result_index, last_element, singular,
                 saturated, input ready);
  modport sink(input valid, result_value, result_index, last_element, singular,
               saturated, output ready);
endinterface

@@ design/matrix4_inverse_unit.sv @@
// 4x4 matrix inverse, signed Q16.16. Elements arrive one per item with their
// column-major index and are stored in a 64-entry scratch memory. An element
// with index 15 starts a run: 88 micro-ops (18 minors, 16 cofactors,
// determinant) on one shared multiplier, each micro-op passing through memory
// read, multiply, round, and accumulate and write back; then a restoring
// divider for the reciprocal at one quotient bit per cycle; then 16 results,
// each one more micro-op that waits while the output is stalled. Inputs are
// taken only while no run is active. A zero determinant gives 16 zero results
// flagged singular. Depends on mi4_pkg, mi4_in_if and mi4_out_if.
module matrix4_inverse_unit import mi4_pkg::*; (
  input  logic clk,
  input  logic rst,
  mi4_in_if.sink    element,
  mi4_out_if.source result
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_RND  = 8'b0000_1000,
    S_ACC  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_INV  = 8'b0100_0000,
    S_SING = 8'b1000_0000
  } state_t;

  state_t     state;
  sec_t       sec;
  logic [4:0] k;
  logic [1:0] j;
  uop_t       u;

  // scratch memory, bit ELEM_WIDTH carries the clip flag of the stored value
  logic [ELEM_WIDTH:0] mem [MEM_DEPTH];
  logic [ELEM_WIDTH:0] rd_a, rd_b;
  logic                wr_en;
  addr_t               wr_addr;
  logic [ELEM_WIDTH:0] wr_data;

  logic [PROD_W-1:0] prod;
  logic              p_neg, p_clip;
  elem_t             fx;
  logic              fx_clip;
  elem_t             acc;
  logic              ec;
  logic              shared;

  elem_t                  a_in, b_in, a_op;
  logic                   nclip;
  logic [ELEM_WIDTH-1:0]  a_mag, b_mag;
  logic [PROD_W:0]        rsum;
  logic [ELEM_WIDTH:0]    fx_res, as_res, inv_res;
  elem_t                  acc_new;
  logic                   ec_new;

  logic [NUM_W-1:0]      div_num, div_q;
  logic [ELEM_WIDTH:0]   div_rem, div_sh;
  logic [ELEM_WIDTH-1:0] div_d, det_mag;
  logic [DIV_CW-1:0]     div_cnt;
  logic                  det_neg;

  logic       o_valid, o_last, o_sing, o_sat;
  elem_t      o_value;
  idx_t       o_index;
  logic       out_free, in_acc, stall, o_load;
  logic [4:0] last_k;
  logic [1:0] last_j;

  assign u        = get_uop(sec, k, j);
  assign in_acc   = element.valid && element.ready;
  assign out_free = !o_valid || result.ready;
  assign stall    = (u.fin == END_OUT) && !out_free;
  assign o_load   = ((state == S_ACC) && !stall && (u.fin == END_OUT)) ||
                    ((state == S_SING) && out_free);

  assign element.ready       = (state == S_IDLE);
  assign result.valid        = o_valid;
  assign result.result_value = o_value;
  assign result.result_index = o_index;
  assign result.last_element = o_last;
  assign result.singular     = o_sing;
  assign result.saturated    = o_sat;

  always_comb begin
    case (sec)
      SEC_MINOR: begin last_k = 5'd17; last_j = 2'd1; end
      SEC_COFAC: begin last_k = 5'd15; last_j = 2'd2; end
      SEC_DET:   begin last_k = 5'd0;  last_j = 2'd3; end
      SEC_RES:   begin last_k = 5'd15; last_j = 2'd0; end
      default:   begin last_k = 5'd0;  last_j = 2'd0; end
    endcase
  end

  // operand A negation (checkerboard sign) and magnitudes for the multiplier
  always_comb begin
    a_in  = elem_t'(rd_a[ELEM_WIDTH-1:0]);
    b_in  = elem_t'(rd_b[ELEM_WIDTH-1:0]);
    nclip = 1'b0;
    a_op  = a_in;
    if (u.neg_a) begin
      if (a_in == ELEM_MIN) begin
        a_op  = ELEM_MAX;
        nclip = 1'b1;
      end else begin
        a_op = -a_in;
      end
    end
    a_mag = a_op[ELEM_WIDTH-1] ? -a_op : a_op;
    b_mag = b_in[ELEM_WIDTH-1] ? -b_in : b_in;
  end

  // round half away from zero on the magnitude, then clip
  always_comb begin
    rsum   = {1'b0, prod} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
    fx_res = from_mag(p_neg, MAG_W'(rsum[PROD_W:FRAC_BITS]));
  end

  always_comb begin
    as_res = sat_addsub(acc, fx, u.op == OP_SUB);
    case (u.op)
      OP_FIRST: begin
        acc_new = fx;
        ec_new  = fx_clip;
      end
      default: begin
        acc_new = as_res[ELEM_WIDTH-1:0];
        ec_new  = ec | fx_clip | as_res[ELEM_WIDTH];
      end
    endcase
  end

  assign det_mag = acc_new[ELEM_WIDTH-1] ? -acc_new : acc_new;
  assign div_sh  = {div_rem[ELEM_WIDTH-1:0], div_num[NUM_W-1]};
  assign inv_res = from_mag(det_neg, MAG_W'(div_q));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = u.dest;
    wr_data = {ec_new, acc_new};
    case (state)
      S_IDLE: begin
        wr_en   = in_acc;
        wr_addr = ADDR_W'(element.element_index);
        wr_data = {1'b0, element.element_value};
      end
      S_ACC: wr_en = (u.fin == END_MINOR) || (u.fin == END_STORE);
      S_INV: begin
        wr_en   = 1'b1;
        wr_addr = INV_ADDR;
        wr_data = {1'b0, inv_res[ELEM_WIDTH-1:0]};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a <= mem[u.a_addr];
    rd_b <= mem[u.b_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod   <= a_mag * b_mag;
      p_neg  <= a_op[ELEM_WIDTH-1] ^ b_in[ELEM_WIDTH-1];
      p_clip <= nclip | rd_a[ELEM_WIDTH] | rd_b[ELEM_WIDTH];
    end
    if (state == S_RND) begin
      fx      <= fx_res[ELEM_WIDTH-1:0];
      fx_clip <= p_clip | fx_res[ELEM_WIDTH];
    end
    if (state == S_ACC && !stall) begin
      acc <= acc_new;
      ec  <= ec_new;
    end
    if (state == S_ACC && u.fin == END_DET) begin
      div_d   <= det_mag;
      det_neg <= acc_new[ELEM_WIDTH-1];
      div_num <= (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(det_mag >> 1);
      div_rem <= '0;
      div_q   <= '0;
      div_cnt <= '0;
    end
    if (state == S_DIV) begin
      div_num <= div_num << 1;
      div_cnt <= div_cnt + 1'b1;
      if (div_sh >= {1'b0, div_d}) begin
        div_rem <= div_sh - {1'b0, div_d};
        div_q   <= {div_q[NUM_W-2:0], 1'b1};
      end else begin
        div_rem <= div_sh;
        div_q   <= {div_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sec     <= SEC_MINOR;
      k       <= '0;
      j       <= '0;
      shared  <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (o_load) o_valid <= 1'b1;
      else if (result.ready) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc && element.element_index == LAST_IDX) begin
            shared <= 1'b0;
            sec    <= SEC_MINOR;
            k      <= '0;
            j      <= '0;
            state  <= S_RD;
          end
        end
        S_RD:  state <= S_MUL;
        S_MUL: state <= S_RND;
        S_RND: state <= S_ACC;
        S_ACC: begin
          if (!stall) begin
            if (u.fin == END_MINOR) shared <= shared | ec_new;
            if (u.fin == END_OUT) begin
              o_value <= acc_new;
              o_index <= k[IDX_W-1:0];
              o_last  <= (k == 5'd15);
              o_sing  <= 1'b0;
              o_sat   <= shared | ec_new;
            end
            if (u.fin == END_DET) begin
              shared <= shared | ec_new;
              k      <= '0;
              state  <= (acc_new == '0) ? S_SING : S_DIV;
            end else if (j != last_j) begin
              j     <= j + 1'b1;
              state <= S_RD;
            end else if (k != last_k) begin
              j     <= '0;
              k     <= k + 1'b1;
              state <= S_RD;
            end else begin
              j <= '0;
              k <= '0;
              case (sec)
                SEC_MINOR: begin sec <= SEC_COFAC; state <= S_RD; end
                SEC_COFAC: begin sec <= SEC_DET;   state <= S_RD; end
                default:   state <= S_IDLE;
              endcase
            end
          end
        end
        S_DIV: begin
          if (div_cnt == DIV_CW'(NUM_W - 1)) state <= S_INV;
        end
        S_INV: begin
          shared <= shared | inv_res[ELEM_WIDTH];
          sec    <= SEC_RES;
          k      <= '0;
          j      <= '0;
          state  <= S_RD;
        end
        S_SING: begin
          if (out_free) begin
            o_value <= '0;
            o_index <= k[IDX_W-1:0];
            o_last  <= (k == 5'd15);
            o_sing  <= 1'b1;
            o_sat   <= 1'b0;
            k       <= k + 1'b1;
            if (k == 5'd15) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    in_acc && element.element_index == LAST_IDX |=> state == S_RD)
    else $error("run did not start after the last element");

  a_no_matrix_clobber: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) && wr_en |-> wr_addr >= MINOR_BASE)
    else $error("run wrote into the matrix area");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.singular |-> result.result_value == '0 && !result.saturated)
    else $error("singular item carries a value");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last_element |-> result.result_index == LAST_IDX)
    else $error("last item with wrong index");
`endif

endmodule
